FILE: hw/rtl/isp_pkg.sv
// Shared types, constants and fixed-point helpers for the inertial scroller.
package isp_pkg;

  localparam int unsigned PosW  = 24;
  localparam int unsigned ProdW = 68;
  localparam int unsigned McW   = 48;
  localparam int unsigned MpW   = 20;
  localparam int unsigned FacW  = 17;

  localparam logic signed [PosW-1:0] PosMax    = 24'sh7FFFFF;
  localparam logic signed [PosW-1:0] PosMin    = 24'sh800000;
  localparam logic signed [PosW-1:0] RelLimit  = 24'sd1024000;
  localparam logic signed [PosW-1:0] Overshoot = 24'sd15360;
  localparam logic signed [PosW-1:0] StopSpeed = 24'sd256;
  localparam logic signed [PosW-1:0] RestSpeed = 24'sd128;
  localparam logic [MpW-1:0]         BounceQ16 = 20'd19661;
  localparam logic [15:0]            DragMinDt = 16'd7;
  localparam logic [15:0]            DefDecay  = 16'd1024;
  localparam logic [19:0]            DefStiff  = 20'd35840;
  localparam logic [15:0]            DefDamp   = 16'd5120;
  localparam logic [ProdW-1:0]       XLimit    = 68'd4096;
  localparam logic [5:0]             DivSteps  = 6'd40;

  typedef enum logic [1:0] {
    FUNC_DRAG, FUNC_RELEASE, FUNC_STEP, FUNC_HOME
  } func_e;

  typedef enum logic [2:0] {
    REG_MIN_POS, REG_MAX_POS, REG_DECAY, REG_STIFF, REG_DAMP
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DRAG, OP_DRAG_VEL, OP_RELEASE, OP_HOME,
    OP_ACC_SET, OP_ACC_SUB, OP_VEL_ACC, OP_POS_ADV, OP_LIM_LO, OP_LIM_HI,
    OP_BOUNCE, OP_FAC, OP_VEL_FRIC, OP_CLAMP, OP_OUT
  } dp_op_e;

  typedef enum logic [2:0] {
    MS_SPRING, MS_DAMP, MS_ACC, MS_VELDT, MS_BOUNCE, MS_DECAY, MS_FRIC
  } mul_sel_e;

  typedef struct packed {
    dp_op_e   op;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     div_start;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  skip;
    logic  outside;
    logic  below_lo;
    logic  above_hi;
    logic  mul_busy;
    logic  div_busy;
  } dp_stat_t;

  // Shift right by 16 or 24, rounding half away from zero.
  function automatic logic signed [ProdW-1:0] rsh_round(input logic signed [ProdW-1:0] v,
                                                       input logic by24);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] rnd;
    mag = v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
    if (by24) begin
      rnd = (mag + (ProdW'(1) << 23)) >> 24;
    end else begin
      rnd = (mag + (ProdW'(1) << 15)) >> 16;
    end
    return v[ProdW-1] ? -$signed(rnd) : $signed(rnd);
  endfunction

  function automatic logic signed [PosW-1:0] sat24(input logic signed [ProdW-1:0] v);
    if (v > 68'sd8388607) begin
      return PosMax;
    end else if (v < -68'sd8388608) begin
      return PosMin;
    end
    return v[PosW-1:0];
  endfunction

endpackage

FILE: hw/rtl/isp_exp_rom.sv
// Constant exp(-x) table, Q1.16, with a registered read port.
module isp_exp_rom import isp_pkg::*; #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] addr_i,
  output logic [FacW-1:0]  data_o
);

  typedef logic [FacW-1:0] tab_t [Depth];

  function automatic tab_t build_tab();
    tab_t            t;
    logic [63:0]     num, n, f, term, r;
    longint          sum;
    for (int i = 0; i < Depth; i++) begin
      num  = 64'(i) * 64'd16;
      n    = num / 64'(Depth);
      f    = ((num % 64'(Depth)) << 32) / 64'(Depth);
      term = 64'd1 << 32;
      sum  = longint'(term);
      for (int k = 1; k <= 24; k++) begin
        term = ((term * f) >> 32) / 64'(k);
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      r = 64'(sum);
      for (longint j = 0; j < longint'(n); j++) begin
        r = (r * 64'd1580030169) >> 32;
      end
      t[i] = FacW'((r + 64'h8000) >> 16);
    end
    return t;
  endfunction

  localparam tab_t Tab = build_tab();

  always_ff @(posedge clk_i) begin
    data_o <= Tab[addr_i];
  end

endmodule

FILE: hw/rtl/isp_datapath.sv
// Datapath: state, config registers, serial multiplier, serial divider, table lookup.
module isp_datapath import isp_pkg::*; #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [23:0]            cfg_wdata_i,
  input  logic [1:0]             func_i,
  input  logic signed [PosW-1:0] drag_delta_i,
  input  logic [15:0]            time_delta_i,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  output logic signed [PosW-1:0] position_o,
  output logic signed [PosW-1:0] velocity_o,
  output logic                   is_dragging_o,
  output logic                   at_rest_o
);

  localparam int unsigned AddrW = $clog2(EXP_TABLE_DEPTH);

  logic signed [PosW-1:0] min_q, max_q, pos_q, vel_q, delta_q;
  logic [15:0]            decay_q, damp_q, dt_q;
  logic [19:0]            stiff_q;
  func_e                  func_q;
  logic                   drag_q, fac_zero_q;
  logic signed [McW-1:0]  acc_q;

  logic signed [ProdW-1:0] mc_q, prod_q;
  logic [MpW-1:0]          mp_q;
  logic                    mbusy_q;

  logic [15:0] rem_q;
  logic [39:0] quo_q;
  logic [5:0]  dcnt_q;
  logic        dneg_q;

  logic [FacW-1:0]  rom_data;
  logic [AddrW-1:0] rom_addr;

  logic signed [PosW-1:0]  lo, hi, bound, clamp_pos, clamp_vel;
  logic signed [PosW:0]    pos_off;
  logic signed [McW-1:0]   mcand;
  logic [MpW-1:0]          mplier;
  logic signed [ProdW-1:0] r16, r24, quo_s;
  logic [31:0]             idx_w;
  logic [PosW-1:0]         delta_mag;
  logic [17:0]             trial;
  logic [16:0]             shifted;

  assign lo    = sat24(ProdW'(min_q) - ProdW'(Overshoot));
  assign hi    = sat24(ProdW'(max_q) + ProdW'(Overshoot));
  assign bound = (pos_q < min_q) ? min_q : max_q;
  assign pos_off = (PosW+1)'(pos_q) - (PosW+1)'(bound);
  assign r16   = rsh_round(prod_q, 1'b0);
  assign r24   = rsh_round(prod_q, 1'b1);
  assign idx_w = (32'(r16[11:0]) * 32'(EXP_TABLE_DEPTH)) >> 12;
  assign rom_addr  = idx_w[AddrW-1:0];
  assign delta_mag = delta_q[PosW-1] ? PosW'(-delta_q) : PosW'(delta_q);
  assign quo_s     = dneg_q ? -$signed(ProdW'(quo_q)) : $signed(ProdW'(quo_q));
  assign shifted   = {rem_q, quo_q[39]};
  assign trial     = {1'b0, shifted} - {2'b0, dt_q};

  isp_exp_rom #(.Depth(EXP_TABLE_DEPTH)) u_rom (
    .clk_i,
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  always_comb begin
    mcand  = McW'(vel_q);
    mplier = MpW'(dt_q);
    case (cmd_i.mul_sel)
      MS_SPRING: begin
        mcand  = McW'(pos_off);
        mplier = stiff_q;
      end
      MS_DAMP:   mplier = MpW'(damp_q);
      MS_ACC:    mcand  = acc_q;
      MS_BOUNCE: mplier = BounceQ16;
      MS_DECAY:  mcand  = $signed(McW'(decay_q));
      MS_FRIC:   mplier = fac_zero_q ? '0 : MpW'(rom_data);
      default:   mcand  = McW'(vel_q);
    endcase
  end

  // Friction end of step: clamp to the bounds, then stop slow motion.
  always_comb begin
    clamp_pos = pos_q;
    clamp_vel = vel_q;
    if (clamp_pos < min_q) begin
      clamp_pos = min_q;
      if (clamp_vel < 0) clamp_vel = '0;
    end
    if (clamp_pos > max_q) begin
      clamp_pos = max_q;
      if (clamp_vel > 0) clamp_vel = '0;
    end
    if (clamp_vel < StopSpeed && clamp_vel > -StopSpeed) clamp_vel = '0;
  end

  always_comb begin
    stat_o.func     = func_q;
    stat_o.skip     = drag_q || (dt_q == '0);
    stat_o.outside  = (pos_q < min_q) || (pos_q > max_q);
    stat_o.below_lo = pos_q < lo;
    stat_o.above_hi = pos_q > hi;
    stat_o.mul_busy = mbusy_q;
    stat_o.div_busy = (dcnt_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      max_q   <= '0;
      decay_q <= DefDecay;
      stiff_q <= DefStiff;
      damp_q  <= DefDamp;
      pos_q   <= '0;
      vel_q   <= '0;
      drag_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_POS: min_q   <= cfg_wdata_i;
          REG_MAX_POS: max_q   <= cfg_wdata_i;
          REG_DECAY:   decay_q <= cfg_wdata_i[15:0];
          REG_STIFF:   stiff_q <= cfg_wdata_i[19:0];
          REG_DAMP:    damp_q  <= cfg_wdata_i[15:0];
          default:     ;
        endcase
      end
      case (cmd_i.op)
        OP_DRAG: begin
          drag_q <= 1'b1;
          pos_q  <= sat24(ProdW'(pos_q) + ProdW'(delta_q));
        end
        OP_DRAG_VEL: vel_q <= (dt_q >= DragMinDt) ? sat24(quo_s) : '0;
        OP_RELEASE: begin
          drag_q <= 1'b0;
          if (vel_q > RelLimit) vel_q <= RelLimit;
          else if (vel_q < -RelLimit) vel_q <= -RelLimit;
        end
        OP_HOME: begin
          pos_q   <= min_q;
          vel_q   <= '0;
          drag_q  <= 1'b0;
          decay_q <= DefDecay;
          stiff_q <= DefStiff;
          damp_q  <= DefDamp;
        end
        OP_VEL_ACC:  vel_q <= sat24(ProdW'(vel_q) + r24);
        OP_POS_ADV:  pos_q <= sat24(ProdW'(pos_q) + r16);
        OP_LIM_LO:   pos_q <= lo;
        OP_LIM_HI:   pos_q <= hi;
        OP_BOUNCE:   vel_q <= sat24(-r16);
        OP_VEL_FRIC: vel_q <= sat24(r16);
        OP_CLAMP: begin
          pos_q <= clamp_pos;
          vel_q <= clamp_vel;
        end
        default: ;
      endcase
    end
  end

  // Operand capture, spring accumulator, table flag and result register.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q  <= func_e'(func_i);
        delta_q <= drag_delta_i;
        dt_q    <= time_delta_i;
      end
      OP_ACC_SET: acc_q <= -prod_q[McW-1:0];
      OP_ACC_SUB: acc_q <= acc_q - prod_q[McW-1:0];
      OP_FAC:     fac_zero_q <= (r16 >= $signed(XLimit));
      OP_OUT: begin
        position_o    <= pos_q;
        velocity_o    <= vel_q;
        is_dragging_o <= drag_q;
        at_rest_o     <= !drag_q && vel_q < RestSpeed && vel_q > -RestSpeed &&
                         pos_q >= min_q && pos_q <= max_q;
      end
      default: ;
    endcase
  end

  // Shift-add multiplier: one multiplier bit a cycle, stops once the rest is zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
    end else if (cmd_i.mul_start) begin
      mbusy_q <= 1'b1;
    end else if (mbusy_q && mp_q == '0) begin
      mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mc_q   <= ProdW'(mcand);
      mp_q   <= mplier;
      prod_q <= '0;
    end else if (mbusy_q && mp_q != '0) begin
      if (mp_q[0]) prod_q <= prod_q + mc_q;
      mc_q <= mc_q <<< 1;
      mp_q <= mp_q >> 1;
    end
  end

  // Restoring divider for the drag speed: |delta| * 2^16 / dt, one bit a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DivSteps;
    end else if (dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= {delta_mag, 16'b0};
      dneg_q <= delta_q[PosW-1];
    end else if (dcnt_q != '0) begin
      if (!trial[17]) begin
        rem_q <= trial[15:0];
        quo_q <= {quo_q[38:0], 1'b1};
      end else begin
        rem_q <= shifted[15:0];
        quo_q <= {quo_q[38:0], 1'b0};
      end
    end
  end

endmodule

FILE: hw/rtl/isp_ctrl.sv
// Controller: sequences one request through the datapath and owns the handshakes.
module isp_ctrl import isp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DISP  = 5'd1;
  localparam logic [4:0] ST_DIV   = 5'd2;
  localparam logic [4:0] ST_M1    = 5'd3;
  localparam logic [4:0] ST_M2    = 5'd4;
  localparam logic [4:0] ST_M3S   = 5'd5;
  localparam logic [4:0] ST_M3    = 5'd6;
  localparam logic [4:0] ST_M4S   = 5'd7;
  localparam logic [4:0] ST_M4    = 5'd8;
  localparam logic [4:0] ST_LO    = 5'd9;
  localparam logic [4:0] ST_B1    = 5'd10;
  localparam logic [4:0] ST_HI    = 5'd11;
  localparam logic [4:0] ST_B2    = 5'd12;
  localparam logic [4:0] ST_F1    = 5'd13;
  localparam logic [4:0] ST_F2S   = 5'd14;
  localparam logic [4:0] ST_F2    = 5'd15;
  localparam logic [4:0] ST_F3S   = 5'd16;
  localparam logic [4:0] ST_F3    = 5'd17;
  localparam logic [4:0] ST_CLAMP = 5'd18;
  localparam logic [4:0] ST_OUT   = 5'd19;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, mul_start: 1'b0, mul_sel: MS_VELDT, div_start: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (stat_i.func)
          FUNC_DRAG: begin
            cmd_o.op        = OP_DRAG;
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
          FUNC_RELEASE: begin
            cmd_o.op = OP_RELEASE;
            state_d  = ST_OUT;
          end
          FUNC_HOME: begin
            cmd_o.op = OP_HOME;
            state_d  = ST_OUT;
          end
          FUNC_STEP: begin
            if (stat_i.skip) begin
              state_d = ST_OUT;
            end else if (stat_i.outside) begin
              cmd_o.mul_start = 1'b1;
              cmd_o.mul_sel   = MS_SPRING;
              state_d         = ST_M1;
            end else begin
              cmd_o.mul_start = 1'b1;
              cmd_o.mul_sel   = MS_DECAY;
              state_d         = ST_F1;
            end
          end
        endcase
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_DRAG_VEL;
          state_d  = ST_OUT;
        end
      end
      ST_M1: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op        = OP_ACC_SET;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MS_DAMP;
          state_d         = ST_M2;
        end
      end
      ST_M2: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_ACC_SUB;
          state_d  = ST_M3S;
        end
      end
      ST_M3S: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_ACC;
        state_d         = ST_M3;
      end
      ST_M3: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_VEL_ACC;
          state_d  = ST_M4S;
        end
      end
      ST_M4S: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_VELDT;
        state_d         = ST_M4;
      end
      ST_M4: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_POS_ADV;
          state_d  = ST_LO;
        end
      end
      ST_LO: begin
        if (stat_i.below_lo) begin
          cmd_o.op        = OP_LIM_LO;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MS_BOUNCE;
          state_d         = ST_B1;
        end else begin
          state_d = ST_HI;
        end
      end
      ST_B1: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_BOUNCE;
          state_d  = ST_HI;
        end
      end
      ST_HI: begin
        if (stat_i.above_hi) begin
          cmd_o.op        = OP_LIM_HI;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MS_BOUNCE;
          state_d         = ST_B2;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_B2: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_BOUNCE;
          state_d  = ST_OUT;
        end
      end
      ST_F1: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_FAC;
          state_d  = ST_F2S;
        end
      end
      ST_F2S: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_FRIC;
        state_d         = ST_F2;
      end
      ST_F2: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_VEL_FRIC;
          state_d  = ST_F3S;
        end
      end
      ST_F3S: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MS_VELDT;
        state_d         = ST_F3;
      end
      ST_F3: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_POS_ADV;
          state_d  = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd_o.op = OP_CLAMP;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/inertial_scroll_physics.sv
// Top level of the kinetic scroller: friction, spring past the bounds, bounce stop.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   in       | in_valid_i / in_ready_o | func_i, drag_delta_i, time_delta_i
//   out      | out_valid_o/out_ready_i | position_o, velocity_o, is_dragging_o,
//            |                         | at_rest_o
//   cfg      | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One request at a time. Release, home and a skipped step use neither the
// multiplier nor the divider; drag waits on the 40-step restoring divider.
// A step runs through one shared shift-add multiplier, one multiplier bit a
// cycle and stopping once the remaining bits are zero.
// A finished result sits in the output register; the next request is accepted
// while it waits, and is held in its last state until the slot frees up.
// Reset (async, active low) clears state and restores register defaults.
module inertial_scroll_physics import isp_pkg::*; #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [23:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             func_i,
  input  logic signed [23:0]     drag_delta_i,
  input  logic [15:0]            time_delta_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [23:0]     position_o,
  output logic signed [23:0]     velocity_o,
  output logic                   is_dragging_o,
  output logic                   at_rest_o
);

  // Controller issues one command a cycle; datapath answers with status.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  isp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Datapath holds position, velocity, drag flag, the bound and gain
  // registers, the multiplier, the divider and the exp(-x) table.
  isp_datapath #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .func_i,
    .drag_delta_i,
    .time_delta_i,
    .cmd_i  (cmd),
    .stat_o (stat),
    .position_o,
    .velocity_o,
    .is_dragging_o,
    .at_rest_o
  );

endmodule

FILE: hw/rtl/isp_checker.sv
// Port-level checks for the inertial scroller, bound to the top level.
module isp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [23:0] position_o,
  input logic signed [23:0] velocity_o,
  input logic               is_dragging_o,
  input logic               at_rest_o
);

  // A held result keeps its position and velocity.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_o) &&
    $stable(velocity_o))
    else $error("result changed while stalled");

  // One request in flight: no accept right after an accept.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_rest_not_drag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(at_rest_o && is_dragging_o))
    else $error("at rest while dragging");

  a_rest_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_rest_o |-> velocity_o < 24'sd128 && velocity_o > -24'sd128)
    else $error("at rest with speed");

endmodule

bind inertial_scroll_physics isp_checker u_isp_checker (.*);
